// ----- sv/efc_pkg.sv -----
`timescale 1ns / 1ps

package efc_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;
    // value_res and count packed, padded to whole bytes
    localparam int M_DATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SCAN    = 5'b00010,
        ST_REP_RD  = 5'b00100,
        ST_REP_LD  = 5'b01000,
        ST_REP_OUT = 5'b10000
    } efc_state_t;

endpackage

// ----- sv/element_frequency_counter_unit.sv -----
`timescale 1ns / 1ps
// a counted item that is not closing is held in the sequential scan of the distinct-value
// table, one entry read per cycle from the ram, until it matches or is appended;
// a dropped item that is not closing leaves the unit in idle
// one request at a time; the report steps through read, load and hand-over for each
// result, plus any output stall
// reset: aresetn synchronous active low, clears counters, flags and valid; table
// contents are left as they are and are only read below the entry count

module element_frequency_counter_unit
    import efc_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [VALUE_W-1:0]  s_tdata,   // [31:0] value
    input  logic                s_tlast,   // last
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [31:0] value_res, [38:32] count, zero pad
    output logic                m_tlast,   // last_of_run
    output logic                m_tuser    // overflow
);

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int ENT_W = VALUE_W + CNT_W;
    localparam int WIDE_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

    efc_state_t state_reg, state_next;

    logic [CNT_W-1:0]   entries_reg, entries_next;
    logic [CNT_W-1:0]   seen_reg, seen_next;
    logic               dropped_reg, dropped_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic               last_reg, last_next;

    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic                m_last_reg, m_last_next;
    logic                m_user_reg, m_user_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENT_W-1:0]   ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENT_W-1:0]   ram_rdata;

    logic [VALUE_W-1:0] rd_value;
    logic [CNT_W-1:0]   rd_cnt;
    logic [WIDE_W-1:0]  rd_cnt_wide;
    logic               issue_ok;
    logic               accept_in;

    efc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ITEMS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_value    = ram_rdata[ENT_W-1:CNT_W];
    assign rd_cnt      = ram_rdata[CNT_W-1:0];
    assign rd_cnt_wide = WIDE_W'(rd_cnt);
    assign issue_ok    = (idx_reg < entries_reg);
    assign s_tready    = (state_reg == ST_IDLE);
    assign accept_in   = s_tvalid && s_tready;

    always_comb begin
        state_next     = state_reg;
        entries_next   = entries_reg;
        seen_next      = seen_reg;
        dropped_next   = dropped_reg;
        idx_next       = idx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        val_next       = val_reg;
        last_next      = last_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;
        m_user_next    = m_user_reg;
        ram_we         = 1'b0;
        ram_waddr      = entries_reg[IDX_W-1:0];
        ram_wdata      = {val_reg, CNT_W'(1)};
        ram_re         = 1'b0;
        ram_raddr      = idx_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (accept_in) begin
                    val_next  = s_tdata;
                    last_next = s_tlast;
                    idx_next  = '0;
                    if (seen_reg >= MAX_CNT) begin
                        // counted-request limit reached: drop, but a closing request still reports
                        dropped_next = 1'b1;
                        if (s_tlast) begin
                            state_next = ST_REP_RD;
                        end
                    end else begin
                        seen_next  = seen_reg + 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (cmp_valid_reg && (rd_value == val_reg)) begin
                    ram_we     = 1'b1;
                    ram_waddr  = cmp_idx_reg;
                    ram_wdata  = {val_reg, rd_cnt + 1'b1};
                    idx_next   = '0;
                    state_next = last_reg ? ST_REP_RD : ST_IDLE;
                end else if (!cmp_valid_reg && !issue_ok) begin
                    // no match anywhere: append a new entry
                    ram_we       = 1'b1;
                    entries_next = entries_reg + 1'b1;
                    idx_next     = '0;
                    state_next   = last_reg ? ST_REP_RD : ST_IDLE;
                end else begin
                    ram_re         = issue_ok;
                    cmp_valid_next = issue_ok;
                    cmp_idx_next   = idx_reg[IDX_W-1:0];
                    idx_next       = issue_ok ? idx_reg + 1'b1 : idx_reg;
                end
            end
            ST_REP_RD: begin
                ram_re     = 1'b1;
                state_next = ST_REP_LD;
            end
            ST_REP_LD: begin
                m_valid_next = 1'b1;
                m_data_next  = M_DATA_W'({rd_cnt_wide[COUNT_W-1:0], rd_value});
                m_last_next  = ((idx_reg + 1'b1) == entries_reg);
                m_user_next  = dropped_reg;
                state_next   = ST_REP_OUT;
            end
            ST_REP_OUT: begin
                if (m_tready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        entries_next = '0;
                        seen_next    = '0;
                        dropped_next = 1'b0;
                        state_next   = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_REP_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            entries_reg   <= '0;
            seen_reg      <= '0;
            dropped_reg   <= 1'b0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            entries_reg   <= entries_next;
            seen_reg      <= seen_next;
            dropped_reg   <= dropped_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg <= cmp_idx_next;
        val_reg     <= val_next;
        last_reg    <= last_next;
        m_data_reg  <= m_data_next;
        m_last_reg  <= m_last_next;
        m_user_reg  <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    // every stored entry was created by a counted request
    a_entries_le_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        entries_reg <= seen_reg && seen_reg <= MAX_CNT)
        else $error("entry count exceeds counted requests");

    // input and output sides never hand over in the same cycle
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // a pending compare always refers to a stored entry
    a_cmp_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_valid_reg |-> (CNT_W'(cmp_idx_reg) < entries_reg))
        else $error("compare outside stored entries");

    // the report closes with the table empty and the overflow flag cleared
    a_clear_after_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (entries_reg == '0 && !dropped_reg))
        else $error("table not cleared after report");

endmodule

// ----- sv/efc_ram.sv -----
`timescale 1ns / 1ps

module efc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
